// ----- rtl/cafit_pkg.sv -----
// Shared types and constants for the ASCII CAN frame receive table.
// Used by the interfaces, the frame parser, the top level and the checker.
// No dependencies.
package cafit_pkg;

  // Fixed field widths of the channels
  localparam int CHAR_W    = 8;
  localparam int ID_W      = 11;
  localparam int LEN_W     = 4;
  localparam int DATA_W    = 64;
  localparam int OUT_CNT_W = 32;
  localparam int NIB_N     = DATA_W / 4;

  // Parser state widths: the ID sum of three signed hex values fits 18 bits
  localparam int POS_W    = 5;
  localparam int HEX_W    = 9;
  localparam int ID_ACC_W = 18;

  localparam logic [POS_W-1:0] POS_START = 5'd0;
  localparam logic [POS_W-1:0] POS_LEN   = 5'd4;
  localparam logic [POS_W-1:0] POS_DATA  = 5'd5;
  localparam logic [POS_W-1:0] POS_MAX   = 5'd31;

  // ASCII codes used by the hex decode
  localparam logic [CHAR_W-1:0] CHAR_0 = 8'd48;
  localparam logic [CHAR_W-1:0] CHAR_9 = 8'd57;
  localparam logic [CHAR_W-1:0] CHAR_A = 8'd65;
  localparam int HEX_ALPHA_BASE = 10;

  localparam logic signed [HEX_W-1:0] DIGIT_BIAS = 9'sd48;
  localparam logic signed [HEX_W-1:0] ALPHA_BIAS = HEX_W'(CHAR_A - HEX_ALPHA_BASE);

  localparam logic [LEN_W-1:0] LEN_MAX = 4'd15;

  // Frame-end event from the parser to the table control
  typedef struct packed {
    logic              done;   // frame end character taken
    logic              ok;     // frame is stored
    logic [ID_W-1:0]   id;
    logic [LEN_W-1:0]  len;
    logic [DATA_W-1:0] data;
  } parse_evt_t;

endpackage

// ----- rtl/cafit_if.sv -----
// Valid/ready channel interfaces for the ASCII CAN frame receive table.
// Depends on cafit_pkg for the field widths.
interface cafit_in_if;
  logic                           valid;
  logic                           ready;
  logic                           mode;
  logic [cafit_pkg::CHAR_W-1:0]   char_code;
  logic                           frame_end;
  logic [cafit_pkg::ID_W-1:0]     query_id;

  modport source (output valid, mode, char_code, frame_end, query_id, input ready);
  modport sink   (input valid, mode, char_code, frame_end, query_id, output ready);
endinterface

interface cafit_out_if;
  logic                              valid;
  logic                              ready;
  logic [cafit_pkg::ID_W-1:0]        result_id;
  logic                              entry_valid;
  logic [cafit_pkg::LEN_W-1:0]       entry_length;
  logic [cafit_pkg::DATA_W-1:0]      entry_data;
  logic [cafit_pkg::OUT_CNT_W-1:0]   entry_count;

  modport source (output valid, result_id, entry_valid, entry_length, entry_data,
                  entry_count, input ready);
  modport sink   (input valid, result_id, entry_valid, entry_length, entry_data,
                  entry_count, output ready);
endinterface

// ----- rtl/cafit_ram.sv -----
// Generic single-write, single-read synchronous RAM with registered read data.
// Read data holds its value while no read is issued. No dependencies.
module cafit_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // Registered read port
  always_ff @(posedge clk) begin
    if (re) begin
      rdata_r <= mem[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ----- rtl/cafit_parser.sv -----
// Character parser for ASCII standard CAN frames: ID, length and data nibbles.
// Depends on cafit_pkg; emits a parse_evt_t on the frame end character.
module cafit_parser #(
  parameter int TABLE_DEPTH    = 2048,
  parameter int MAX_DATA_BYTES = 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           char_en,
  input  logic [cafit_pkg::CHAR_W-1:0]   char_code,
  input  logic                           frame_end,
  output cafit_pkg::parse_evt_t          evt
);

  localparam int POS_W = cafit_pkg::POS_W;
  localparam logic [POS_W-1:0] DATA_LIMIT = POS_W'(2 * MAX_DATA_BYTES);
  localparam logic signed [cafit_pkg::ID_ACC_W-1:0] ID_LIMIT =
    cafit_pkg::ID_ACC_W'(TABLE_DEPTH);

  logic [POS_W-1:0]                        pos_r, pos_nxt;
  logic signed [cafit_pkg::ID_ACC_W-1:0]   id_r, id_nxt;
  logic [cafit_pkg::LEN_W-1:0]             len_r, len_nxt;
  logic [cafit_pkg::DATA_W-1:0]            data_r, data_nxt;

  logic signed [cafit_pkg::HEX_W-1:0]      hex_v;
  logic                                    is_digit;
  logic [POS_W-1:0]                        nib_k;
  logic                                    keep_nib;

  // Decode one character: digits map to c-48, anything else to c-55
  always_comb begin
    is_digit = (char_code >= cafit_pkg::CHAR_0) && (char_code <= cafit_pkg::CHAR_9);
    if (is_digit) begin
      hex_v = $signed({1'b0, char_code}) - cafit_pkg::DIGIT_BIAS;
    end else begin
      hex_v = $signed({1'b0, char_code}) - cafit_pkg::ALPHA_BIAS;
    end
  end

  // Data slot of this character, kept only within the length and the buffer
  assign nib_k    = pos_r - cafit_pkg::POS_DATA;
  assign keep_nib = (pos_r >= cafit_pkg::POS_DATA) && (nib_k < {len_r, 1'b0}) &&
                    (nib_k < DATA_LIMIT) && (nib_k < POS_W'(cafit_pkg::NIB_N));

  // Fold the character into the frame fields
  always_comb begin
    id_nxt   = id_r;
    len_nxt  = len_r;
    data_nxt = data_r;
    if (pos_r == cafit_pkg::POS_START) begin
      id_nxt   = '0;
      len_nxt  = '0;
      data_nxt = '0;
    end else if (pos_r < cafit_pkg::POS_LEN) begin
      id_nxt = (id_r <<< 4) + cafit_pkg::ID_ACC_W'(hex_v);
    end else if (pos_r == cafit_pkg::POS_LEN) begin
      if (hex_v < 0) begin
        len_nxt = '0;
      end else if (hex_v > $signed(cafit_pkg::HEX_W'(cafit_pkg::LEN_MAX))) begin
        len_nxt = cafit_pkg::LEN_MAX;
      end else begin
        len_nxt = hex_v[cafit_pkg::LEN_W-1:0];
      end
    end else begin
      for (int i = 0; i < cafit_pkg::NIB_N; i++) begin
        if (keep_nib && (nib_k == POS_W'(i))) begin
          data_nxt[(cafit_pkg::NIB_N-1-i)*4 +: 4] = hex_v[3:0];
        end
      end
    end
  end

  // Advance the position with saturation; the end character closes the frame
  always_comb begin
    if (frame_end) begin
      pos_nxt = cafit_pkg::POS_START;
    end else if (pos_r == cafit_pkg::POS_MAX) begin
      pos_nxt = pos_r;
    end else begin
      pos_nxt = pos_r + 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r  <= cafit_pkg::POS_START;
      id_r   <= '0;
      len_r  <= '0;
      data_r <= '0;
    end else if (char_en) begin
      pos_r <= pos_nxt;
      if (frame_end) begin
        id_r   <= '0;
        len_r  <= '0;
        data_r <= '0;
      end else begin
        id_r   <= id_nxt;
        len_r  <= len_nxt;
        data_r <= data_nxt;
      end
    end
  end

  // Frame-end event, taken from the values that include this character
  always_comb begin
    evt.done = char_en && frame_end;
    evt.ok   = (pos_r >= cafit_pkg::POS_LEN) && (id_nxt > 0) && (id_nxt < ID_LIMIT);
    evt.id   = id_nxt[cafit_pkg::ID_W-1:0];
    evt.len  = len_nxt;
    evt.data = data_nxt;
  end

endmodule

// ----- rtl/can_ascii_frame_id_table.sv -----
// Top level of the ASCII CAN frame receive table: parser, entry RAM, control.
// Depends on cafit_pkg, cafit_in_if/cafit_out_if, cafit_parser and cafit_ram.
//
//   channel  | dir | handshake          | payload
//   in_ch    | in  | valid/ready        | mode, char_code, frame_end, query_id
//   out_ch   | out | valid/ready        | result_id, entry_valid, entry_length,
//            |     |                    | entry_data, entry_count
//
// A frame character without frame_end gives no result. A query or a frame
// end issues an entry RAM read, then the response state loads the output
// register and, for a stored frame, writes the entry back.
// After reset a clearing pass writes every entry with in_ch.ready low.
// A full output register holds the response cycle until out_ch.ready;
// the input side is taken again once the response is loaded.
module can_ascii_frame_id_table #(
  parameter int TABLE_DEPTH    = 2048,
  parameter int MAX_DATA_BYTES = 8,
  parameter int COUNT_WIDTH    = 32
) (
  input  logic        clk,
  input  logic        rst_n,
  cafit_in_if.sink    in_ch,
  cafit_out_if.source out_ch
);

  localparam int AW     = $clog2(TABLE_DEPTH);
  localparam int CW     = COUNT_WIDTH;
  localparam int DW     = cafit_pkg::DATA_W;
  localparam int LW     = cafit_pkg::LEN_W;
  localparam int WORD_W = 1 + LW + DW + CW;

  localparam logic [AW-1:0] LAST_ADDR = AW'(TABLE_DEPTH - 1);
  localparam logic [cafit_pkg::ID_W:0] DEPTH_BOUND = (cafit_pkg::ID_W + 1)'(TABLE_DEPTH);

  // Control states
  localparam logic [1:0] ST_CLEAR = 2'd0;
  localparam logic [1:0] ST_IDLE  = 2'd1;
  localparam logic [1:0] ST_RESP  = 2'd2;

  // Kind of pending response
  localparam logic [1:0] KIND_QUERY  = 2'd0;
  localparam logic [1:0] KIND_STORE  = 2'd1;
  localparam logic [1:0] KIND_REJECT = 2'd2;

  logic [1:0]    state_r, state_nxt;
  logic [AW-1:0] clr_addr_r, clr_addr_nxt;

  logic                         accept;
  logic                         char_en;
  logic                         resp_item;
  logic                         resp_fire;
  cafit_pkg::parse_evt_t        evt;

  // Pending response payload
  logic [1:0]                   kind_r;
  logic [cafit_pkg::ID_W-1:0]   pend_id_r;
  logic                         pend_oor_r;
  logic [LW-1:0]                pend_len_r;
  logic [DW-1:0]                pend_data_r;
  logic [AW-1:0]                pend_addr_r;

  // Entry RAM ports
  logic              ram_we;
  logic [AW-1:0]     ram_waddr;
  logic [WORD_W-1:0] ram_wdata;
  logic              ram_re;
  logic [AW-1:0]     ram_raddr;
  logic [WORD_W-1:0] ram_rdata;

  logic          rd_valid;
  logic [LW-1:0] rd_len;
  logic [DW-1:0] rd_data;
  logic [CW-1:0] rd_cnt;
  logic [CW-1:0] cnt_inc;

  // Output register
  logic                              out_valid_r, out_valid_nxt;
  logic [cafit_pkg::ID_W-1:0]        out_id_r;
  logic                              out_ev_r;
  logic [LW-1:0]                     out_len_r;
  logic [DW-1:0]                     out_data_r;
  logic [cafit_pkg::OUT_CNT_W-1:0]   out_cnt_r;

  // Handshake decode
  assign in_ch.ready = (state_r == ST_IDLE);
  assign accept      = in_ch.valid && in_ch.ready;
  assign char_en     = accept && !in_ch.mode;
  assign resp_item   = (accept && in_ch.mode) || evt.done;
  assign resp_fire   = (state_r == ST_RESP) && (!out_valid_r || out_ch.ready);

  cafit_parser #(
    .TABLE_DEPTH    (TABLE_DEPTH),
    .MAX_DATA_BYTES (MAX_DATA_BYTES)
  ) u_parser (
    .clk       (clk),
    .rst_n     (rst_n),
    .char_en   (char_en),
    .char_code (in_ch.char_code),
    .frame_end (in_ch.frame_end),
    .evt       (evt)
  );

  // Entry word: valid mark, length, data, counter
  assign rd_valid = ram_rdata[WORD_W-1];
  assign rd_len   = ram_rdata[CW+DW +: LW];
  assign rd_data  = ram_rdata[CW +: DW];
  assign rd_cnt   = ram_rdata[CW-1:0];
  assign cnt_inc  = rd_cnt + 1'b1;

  // Read on the accepted query or frame end; write on clear or stored frame
  always_comb begin
    ram_re    = resp_item;
    ram_raddr = in_ch.mode ? in_ch.query_id[AW-1:0] : evt.id[AW-1:0];
    ram_we    = 1'b0;
    ram_waddr = pend_addr_r;
    ram_wdata = {1'b1, pend_len_r, pend_data_r, cnt_inc};
    if (state_r == ST_CLEAR) begin
      ram_we    = 1'b1;
      ram_waddr = clr_addr_r;
      ram_wdata = '0;
    end else if (resp_fire && (kind_r == KIND_STORE)) begin
      ram_we = 1'b1;
    end
  end

  cafit_ram #(
    .WIDTH (WORD_W),
    .DEPTH (TABLE_DEPTH)
  ) u_entry_ram (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ram_waddr),
    .wdata (ram_wdata),
    .re    (ram_re),
    .raddr (ram_raddr),
    .rdata (ram_rdata)
  );

  // Sequence clear, idle and response
  always_comb begin
    state_nxt    = state_r;
    clr_addr_nxt = clr_addr_r;
    unique case (state_r)
      ST_CLEAR: begin
        clr_addr_nxt = clr_addr_r + 1'b1;
        if (clr_addr_r == LAST_ADDR) begin
          state_nxt = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (resp_item) begin
          state_nxt = ST_RESP;
        end
      end
      ST_RESP: begin
        if (resp_fire) begin
          state_nxt = ST_IDLE;
        end
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r    <= ST_CLEAR;
      clr_addr_r <= '0;
    end else begin
      state_r    <= state_nxt;
      clr_addr_r <= clr_addr_nxt;
    end
  end

  // Capture what the response cycle needs
  always_ff @(posedge clk) begin
    if (resp_item) begin
      pend_len_r  <= evt.len;
      pend_data_r <= evt.data;
      pend_addr_r <= ram_raddr;
      if (in_ch.mode) begin
        kind_r     <= KIND_QUERY;
        pend_id_r  <= in_ch.query_id;
        pend_oor_r <= ({1'b0, in_ch.query_id} >= DEPTH_BOUND);
      end else begin
        kind_r     <= evt.ok ? KIND_STORE : KIND_REJECT;
        pend_id_r  <= evt.ok ? evt.id : '0;
        pend_oor_r <= 1'b0;
      end
    end
  end

  // Hold the result until taken; a new one loads in the response cycle
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (resp_fire) begin
      out_valid_nxt = 1'b1;
    end else if (out_ch.ready) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (resp_fire) begin
      out_id_r <= pend_id_r;
      unique case (kind_r)
        KIND_STORE: begin
          out_ev_r   <= 1'b1;
          out_len_r  <= pend_len_r;
          out_data_r <= pend_data_r;
          out_cnt_r  <= cafit_pkg::OUT_CNT_W'(cnt_inc);
        end
        KIND_QUERY: begin
          out_ev_r   <= rd_valid && !pend_oor_r;
          out_len_r  <= (rd_valid && !pend_oor_r) ? rd_len : '0;
          out_data_r <= (rd_valid && !pend_oor_r) ? rd_data : '0;
          out_cnt_r  <= pend_oor_r ? '0 : cafit_pkg::OUT_CNT_W'(rd_cnt);
        end
        default: begin
          out_ev_r   <= 1'b0;
          out_len_r  <= '0;
          out_data_r <= '0;
          out_cnt_r  <= '0;
        end
      endcase
    end
  end

  assign out_ch.valid        = out_valid_r;
  assign out_ch.result_id    = out_id_r;
  assign out_ch.entry_valid  = out_ev_r;
  assign out_ch.entry_length = out_len_r;
  assign out_ch.entry_data   = out_data_r;
  assign out_ch.entry_count  = out_cnt_r;

endmodule

// ----- rtl/cafit_chk.sv -----
// Port-level checker for the ASCII CAN frame receive table, bound to the top.
// Depends on cafit_pkg for field widths.
module cafit_chk (
  input logic                              clk,
  input logic                              rst_n,
  input logic                              in_valid,
  input logic                              in_ready,
  input logic                              in_mode,
  input logic                              in_frame_end,
  input logic                              out_valid,
  input logic                              out_ready,
  input logic [cafit_pkg::ID_W-1:0]        out_result_id,
  input logic                              out_entry_valid,
  input logic [cafit_pkg::LEN_W-1:0]       out_entry_length,
  input logic [cafit_pkg::DATA_W-1:0]      out_entry_data,
  input logic [cafit_pkg::OUT_CNT_W-1:0]   out_entry_count
);

  // Keep a stalled result on the port
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid)
    else $error("result dropped while stalled");

  // Block new input in the cycle after a query or frame end
  a_resp_busy: assert property (@(posedge clk) disable iff (!rst_n)
    in_valid && in_ready && (in_mode || in_frame_end) |=> !in_ready)
    else $error("input taken during the entry access");

  // Report ID zero only as an empty entry
  a_zero_id: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && (out_result_id == '0) |->
      !out_entry_valid && (out_entry_length == '0) && (out_entry_data == '0) &&
      (out_entry_count == '0))
    else $error("nonzero fields with ID zero");

  // Show no length or data for an unmarked entry
  a_empty_entry: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_entry_valid |->
      (out_entry_length == '0) && (out_entry_data == '0))
    else $error("length or data on an unmarked entry");

endmodule

bind can_ascii_frame_id_table cafit_chk u_cafit_chk (
  .clk              (clk),
  .rst_n            (rst_n),
  .in_valid         (in_ch.valid),
  .in_ready         (in_ch.ready),
  .in_mode          (in_ch.mode),
  .in_frame_end     (in_ch.frame_end),
  .out_valid        (out_ch.valid),
  .out_ready        (out_ch.ready),
  .out_result_id    (out_ch.result_id),
  .out_entry_valid  (out_ch.entry_valid),
  .out_entry_length (out_ch.entry_length),
  .out_entry_data   (out_ch.entry_data),
  .out_entry_count  (out_ch.entry_count)
);
